@@ src/handle_pool_allocator_core_assert.svh @@
// ----------------------------------------------------------------------------
// handle pool allocator assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef HANDLE_POOL_ALLOCATOR_CORE_ASSERT_SVH
`define HANDLE_POOL_ALLOCATOR_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define HPA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent at the same edge
`define HPA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent at the next edge
`define HPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/hpa_pkg.sv @@
// ----------------------------------------------------------------------------
// hpa_pkg
// sizes, action codes and status codes of the handle pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package hpa_pkg;

    localparam int POOL_SIZE = 256;
    localparam int PTR_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int HANDLE_W  = 8;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_status;

    localparam t_action ACT_ALLOC   = 2'd0;
    localparam t_action ACT_TRY     = 2'd1;
    localparam t_action ACT_RELEASE = 2'd2;

    localparam t_status ST_OK            = 2'd0;
    localparam t_status ST_NONE_RELEASED = 2'd1;
    localparam t_status ST_NOT_ALLOCATED = 2'd2;
    localparam t_status ST_EXHAUSTED     = 2'd3;

endpackage

`default_nettype wire

@@ src/hpa_ram.sv @@
// ----------------------------------------------------------------------------
// hpa_ram
// simple dual-port ram, one write and one registered read, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/handle_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// handle_pool_allocator_core
// handle allocator with first-in first-out reuse of released handles
// ----------------------------------------------------------------------------
// Each request allocates, try-allocates or releases a handle and yields one
// result, held first in the input register and then in the result register.
// A new request is taken every cycle while results are drained: the
// released-handle queue lives in a ram whose head entry is read ahead, and
// the allocated bitmap is a one-bit ram read as the request is registered,
// with the bitmap write of the request ahead forwarded, so a pop or push
// and one bitmap access finish together in the decode cycle. Bitmap
// entries at or above the fresh handle counter count as clear, so no clearing
// pass is needed after reset.
`default_nettype none

`include "handle_pool_allocator_core_assert.svh"

module handle_pool_allocator_core
    import hpa_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_action,
    input  wire logic [HANDLE_W-1:0] i_handle,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [HANDLE_W-1:0] o_granted_handle,
    output logic      [1:0]          o_status
);

    // input register
    logic                r_in_valid;
    t_action             r_action;
    logic [HANDLE_W-1:0] r_handle;

    // queue and pool state
    logic [PTR_W-1:0]    r_head, n_head;
    logic [PTR_W-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_fresh, n_fresh;

    // head bypass for a write that lands on the prefetched entry
    logic                r_byp_valid;
    logic [PTR_W-1:0]    r_byp_data;

    // bitmap forward for a write that lands on the entry being read
    logic                r_mfwd_valid;
    logic                r_mfwd_val;

    // result register
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_granted;
    t_status             r_status;

    logic                advance;
    logic [PTR_W-1:0]    ram_rdata;
    logic [PTR_W-1:0]    pop_data;
    logic [PTR_W-1:0]    handle_idx;
    logic                handle_seen;
    logic                push_we;
    logic                map_we;
    logic                map_val;
    logic [PTR_W-1:0]    map_idx;
    logic [PTR_W-1:0]    map_raddr;
    logic                map_rdata;
    logic                map_bit;
    logic [HANDLE_W-1:0] grant;
    t_status             status;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    assign pop_data    = r_byp_valid ? r_byp_data : ram_rdata;
    assign handle_idx  = PTR_W'(r_handle);
    assign handle_seen = CNT_W'(r_handle) < r_fresh;
    assign map_raddr   = (i_in_valid && !o_in_stall) ? PTR_W'(i_handle) : handle_idx;
    assign map_bit     = r_mfwd_valid ? r_mfwd_val : map_rdata;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_fresh = r_fresh;
        push_we = 1'b0;
        map_we  = 1'b0;
        map_val = 1'b0;
        map_idx = handle_idx;
        grant   = '0;
        status  = ST_OK;
        if (advance) begin
            case (r_action) inside
                ACT_ALLOC, ACT_TRY: begin
                    if (r_count != '0) begin
                        grant   = HANDLE_W'(pop_data);
                        map_we  = 1'b1;
                        map_val = 1'b1;
                        map_idx = pop_data;
                        n_head  = (r_head == PTR_W'(POOL_SIZE - 1)) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                    end else if (r_action == ACT_TRY) begin
                        status = ST_NONE_RELEASED;
                    end else if (r_fresh < CNT_W'(POOL_SIZE)) begin
                        grant   = HANDLE_W'(r_fresh);
                        map_we  = 1'b1;
                        map_val = 1'b1;
                        map_idx = r_fresh[PTR_W-1:0];
                        n_fresh = r_fresh + 1'b1;
                    end else begin
                        status = ST_EXHAUSTED;
                    end
                end
                ACT_RELEASE: begin
                    if (handle_seen && map_bit) begin
                        map_we = 1'b1;
                        if (r_count < CNT_W'(POOL_SIZE)) begin
                            push_we = 1'b1;
                            n_tail  = (r_tail == PTR_W'(POOL_SIZE - 1)) ? '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        status = ST_NOT_ALLOCATED;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    hpa_ram #(
        .WIDTH (PTR_W),
        .DEPTH (POOL_SIZE)
    ) u_free_queue (
        .i_clk   (i_clk),
        .i_we    (push_we),
        .i_waddr (r_tail),
        .i_wdata (handle_idx),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    hpa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_SIZE)
    ) u_alloc_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_idx),
        .i_wdata (map_val),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_fresh      <= '0;
            r_byp_valid  <= 1'b0;
            r_mfwd_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_fresh      <= n_fresh;
            r_byp_valid  <= push_we && (r_tail == n_head);
            r_mfwd_valid <= map_we && (map_idx == map_raddr);
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= i_action;
            r_handle <= i_handle;
        end
        r_byp_data <= handle_idx;
        r_mfwd_val <= map_val;
        if (advance) begin
            r_granted <= grant;
            r_status  <= status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted_handle = r_granted;
    assign o_status         = r_status;

    `HPA_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(POOL_SIZE),
        "free queue count above pool size")
    `HPA_ASSERT_ALWAYS(a_ptr_match, r_count[PTR_W-1:0] == PTR_W'(r_tail - r_head),
        "free queue count disagrees with pointers")
    `HPA_ASSERT_ALWAYS(a_fresh_bound, r_fresh <= CNT_W'(POOL_SIZE),
        "fresh handle counter past pool size")
    `HPA_ASSERT_IMPL(a_err_no_grant, r_out_valid && r_status != ST_OK, r_granted == '0,
        "failed request carries a handle")
    `HPA_ASSERT_NEXT(a_out_hold, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_granted) && $stable(r_status),
        "stalled result changed")

endmodule

`default_nettype wire
